[rtl/pscr_pkg.sv]
// Shared types, constants and the CRC step for the packet set checker.
// No dependencies; every other rtl file refers to this package by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package pscr_pkg;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    // Field widths
    localparam int DATA_WIDTH   = 8;
    localparam int HDR_WIDTH    = 16;
    localparam int INDEX_WIDTH  = 16;
    localparam int STATUS_WIDTH = 3;
    localparam int CFG_WIDTH    = 24;

    // Packed bus widths
    localparam int S_TDATA_WIDTH = 56;
    localparam int S_TUSER_WIDTH = 2;
    localparam int M_TDATA_WIDTH = 16;
    localparam int M_TUSER_WIDTH = 4;

    // Register reset and parameter defaults
    localparam logic [CFG_WIDTH-1:0] CFG_RESET = 24'd4560;
    localparam int BYTE_COUNT_WIDTH_DEF = 24;
    localparam int QUEUE_DEPTH_DEF      = 4;

    localparam logic [INDEX_WIDTH-1:0] INDEX_MAX = 16'hFFFF;

    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK    = 3'd0,
        ST_COUNT = 3'd1,
        ST_SEQ   = 3'd2,
        ST_CRC   = 3'd3,
        ST_BYTES = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_SEQ  = 2'd1,
        ERR_CRC  = 2'd2
    } err_t;

    // One classified item as it travels through the queue
    typedef struct packed {
        logic [DATA_WIDTH-1:0] data_byte;
        logic                  has_byte;
        logic                  last_in_packet;
        logic                  last_packet;
        logic [HDR_WIDTH-1:0]  header_seq;
        logic [HDR_WIDTH-1:0]  header_total;
        logic [HDR_WIDTH-1:0]  header_crc;
    } item_t;

    // Fold one byte into the CRC, MSB first, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc,
                                             input logic [DATA_WIDTH-1:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/pscr_front.sv]
// Front end: takes input items, drops idle ones, masks stray set marks.
// Depends on pscr_pkg for item_t and field widths.
`timescale 1ns / 1ps
`default_nettype none

module pscr_front (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // data_byte[7:0], header_seq[23:8], header_total[39:24], header_crc[55:40]
    input  wire logic [pscr_pkg::S_TDATA_WIDTH-1:0]  s_axis_tdata,
    input  wire logic                                s_axis_tlast,
    // has_byte[0], last_packet[1]
    input  wire logic [pscr_pkg::S_TUSER_WIDTH-1:0]  s_axis_tuser,
    output logic                                     push_valid,
    input  wire logic                                push_ready,
    output pscr_pkg::item_t                          push_item
);

    logic            stage_valid_reg;
    logic            stage_valid_next;
    pscr_pkg::item_t stage_reg;
    pscr_pkg::item_t item_in;
    logic            accept;
    logic            keep;

    // Unpack and classify the incoming item
    always_comb
    begin
        item_in.data_byte      = s_axis_tdata[7:0];
        item_in.header_seq     = s_axis_tdata[23:8];
        item_in.header_total   = s_axis_tdata[39:24];
        item_in.header_crc     = s_axis_tdata[55:40];
        item_in.has_byte       = s_axis_tuser[0];
        item_in.last_in_packet = s_axis_tlast;
        item_in.last_packet    = s_axis_tuser[1] & s_axis_tlast;
    end

    assign s_axis_tready = !stage_valid_reg || push_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign keep          = item_in.has_byte || item_in.last_in_packet;

    // Hold the stage until the queue takes it; load only items that do work
    always_comb
    begin
        if (s_axis_tready)
            stage_valid_next = accept && keep;
        else
            stage_valid_next = stage_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
            stage_reg <= item_in;
    end

    assign push_valid = stage_valid_reg;
    assign push_item  = stage_reg;

endmodule

`default_nettype wire

[rtl/pscr_queue.sv]
// Short queue of classified items between the front and back ends.
// Depends on pscr_pkg for item_t; DEPTH must be a power of two, at least 2.
`timescale 1ns / 1ps
`default_nettype none

module pscr_queue #(
    parameter int DEPTH = pscr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire pscr_pkg::item_t push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output pscr_pkg::item_t      pop_item
);

    localparam int PTR_W = $clog2(DEPTH);

    pscr_pkg::item_t  slots [DEPTH];
    logic [PTR_W:0]   wr_ptr_reg;
    logic [PTR_W:0]   wr_ptr_next;
    logic [PTR_W:0]   rd_ptr_reg;
    logic [PTR_W:0]   rd_ptr_next;
    logic             full;
    logic             empty;
    logic             push;
    logic             pop;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[PTR_W] != rd_ptr_reg[PTR_W]) &&
                   (wr_ptr_reg[PTR_W-1:0] == rd_ptr_reg[PTR_W-1:0]);

    assign push_ready = !full;
    assign pop_valid  = !empty;
    assign push       = push_valid && !full;
    assign pop        = pop_ready && !empty;
    assign pop_item   = slots[rd_ptr_reg[PTR_W-1:0]];

    // Advance the pointers
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Write the slot
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg[PTR_W-1:0]] <= push_item;
    end

endmodule

`default_nettype wire

[rtl/pscr_back.sv]
// Back end: CRC, packet and byte counters, set status and the result register.
// Depends on pscr_pkg for item_t, codes and the crc_byte function.
`timescale 1ns / 1ps
`default_nettype none

module pscr_back #(
    parameter int BYTE_COUNT_WIDTH = pscr_pkg::BYTE_COUNT_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic [pscr_pkg::CFG_WIDTH-1:0]      expected_set_bytes,
    input  wire logic                                pop_valid,
    output logic                                     pop_ready,
    input  wire pscr_pkg::item_t                     pop_item,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // packet_index[15:0]
    output logic [pscr_pkg::M_TDATA_WIDTH-1:0]       m_axis_tdata,
    output logic                                     m_axis_tlast,
    // packet_good[0], set_status[3:1]
    output logic [pscr_pkg::M_TUSER_WIDTH-1:0]       m_axis_tuser
);

    localparam int CMP_W = (BYTE_COUNT_WIDTH > pscr_pkg::CFG_WIDTH) ?
                           BYTE_COUNT_WIDTH : pscr_pkg::CFG_WIDTH;
    localparam logic [BYTE_COUNT_WIDTH-1:0] BYTES_MAX = '1;

    // Set state
    logic [15:0]                            crc_reg;
    logic [15:0]                            crc_next;
    logic [pscr_pkg::INDEX_WIDTH-1:0]       packets_reg;
    logic [pscr_pkg::INDEX_WIDTH-1:0]       packets_next;
    logic [BYTE_COUNT_WIDTH-1:0]            bytes_reg;
    logic [BYTE_COUNT_WIDTH-1:0]            bytes_next;
    logic [pscr_pkg::HDR_WIDTH-1:0]         first_total_reg;
    logic [pscr_pkg::HDR_WIDTH-1:0]         first_total_next;
    pscr_pkg::err_t                         first_err_reg;
    pscr_pkg::err_t                         first_err_next;

    // Result register
    logic                                   m_valid_reg;
    logic                                   m_valid_next;
    logic [pscr_pkg::INDEX_WIDTH-1:0]       m_index_reg;
    logic                                   m_good_reg;
    logic                                   m_done_reg;
    pscr_pkg::status_t                      m_status_reg;

    // Per-item working values
    logic [15:0]                            crc_upd;
    logic [BYTE_COUNT_WIDTH-1:0]            bytes_upd;
    logic [pscr_pkg::INDEX_WIDTH-1:0]       packets_upd;
    logic [pscr_pkg::HDR_WIDTH-1:0]         total_upd;
    pscr_pkg::err_t                         err_upd;
    pscr_pkg::status_t                      status_upd;
    logic                                   seq_ok;
    logic                                   crc_ok;
    logic                                   bytes_match;
    logic                                   out_free;
    logic                                   pop;
    logic                                   result_load;
    logic                                   set_end;

    assign out_free    = !m_valid_reg || m_axis_tready;
    assign pop_ready   = !pop_item.last_in_packet || out_free;
    assign pop         = pop_valid && pop_ready;
    assign result_load = pop && pop_item.last_in_packet;
    assign set_end     = result_load && pop_item.last_packet;

    // Fold the byte and count it
    always_comb
    begin
        crc_upd = pop_item.has_byte ? pscr_pkg::crc_byte(crc_reg, pop_item.data_byte)
                                    : crc_reg;
        if (pop_item.has_byte && (bytes_reg != BYTES_MAX))
            bytes_upd = bytes_reg + 1'b1;
        else
            bytes_upd = bytes_reg;
    end

    // Check the packet and work out the set status
    always_comb
    begin
        seq_ok      = (pop_item.header_seq == packets_reg);
        crc_ok      = (pop_item.header_crc == crc_upd);
        bytes_match = (CMP_W'(bytes_upd) == CMP_W'(expected_set_bytes));
        total_upd   = (packets_reg == '0) ? pop_item.header_total : first_total_reg;
        packets_upd = (packets_reg != pscr_pkg::INDEX_MAX) ? packets_reg + 1'b1
                                                            : packets_reg;
        err_upd = first_err_reg;
        if (first_err_reg == pscr_pkg::ERR_NONE)
        begin
            if (!seq_ok)
                err_upd = pscr_pkg::ERR_SEQ;
            else if (!crc_ok)
                err_upd = pscr_pkg::ERR_CRC;
        end
        priority if (!pop_item.last_packet)
            status_upd = pscr_pkg::ST_OK;
        else if (packets_upd != total_upd)
            status_upd = pscr_pkg::ST_COUNT;
        else if (err_upd == pscr_pkg::ERR_SEQ)
            status_upd = pscr_pkg::ST_SEQ;
        else if (err_upd == pscr_pkg::ERR_CRC)
            status_upd = pscr_pkg::ST_CRC;
        else if (!bytes_match)
            status_upd = pscr_pkg::ST_BYTES;
        else
            status_upd = pscr_pkg::ST_OK;
    end

    // Advance the set state on each popped item
    always_comb
    begin
        crc_next         = crc_reg;
        bytes_next       = bytes_reg;
        packets_next     = packets_reg;
        first_total_next = first_total_reg;
        first_err_next   = first_err_reg;
        if (set_end)
        begin
            crc_next         = pscr_pkg::CRC_INIT;
            bytes_next       = '0;
            packets_next     = '0;
            first_total_next = '0;
            first_err_next   = pscr_pkg::ERR_NONE;
        end
        else if (result_load)
        begin
            crc_next         = pscr_pkg::CRC_INIT;
            bytes_next       = bytes_upd;
            packets_next     = packets_upd;
            first_total_next = total_upd;
            first_err_next   = err_upd;
        end
        else if (pop)
        begin
            crc_next   = crc_upd;
            bytes_next = bytes_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg         <= pscr_pkg::CRC_INIT;
            bytes_reg       <= '0;
            packets_reg     <= '0;
            first_total_reg <= '0;
            first_err_reg   <= pscr_pkg::ERR_NONE;
        end
        else
        begin
            crc_reg         <= crc_next;
            bytes_reg       <= bytes_next;
            packets_reg     <= packets_next;
            first_total_reg <= first_total_next;
            first_err_reg   <= first_err_next;
        end
    end

    // Result register: load when free, hold while stalled
    always_comb
    begin
        if (out_free)
            m_valid_next = result_load;
        else
            m_valid_next = m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else
            m_valid_reg <= m_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            m_index_reg  <= packets_reg;
            m_good_reg   <= seq_ok && crc_ok;
            m_done_reg   <= pop_item.last_packet;
            m_status_reg <= status_upd;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_index_reg;
    assign m_axis_tlast  = m_done_reg;
    assign m_axis_tuser  = {m_status_reg, m_good_reg};

    // A closed set leaves the state at its reset values
    assert property (@(posedge clk) disable iff (!rst_n)
        set_end |=> (packets_reg == '0) && (bytes_reg == '0) &&
                    (crc_reg == pscr_pkg::CRC_INIT) &&
                    (first_err_reg == pscr_pkg::ERR_NONE))
        else $error("set state not cleared after set end");

    // Only a set-closing result carries a status
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !m_done_reg) |-> (m_status_reg == pscr_pkg::ST_OK))
        else $error("status on a result that does not close the set");

    // The first error of a set is kept until the set ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (first_err_reg != pscr_pkg::ERR_NONE) && !set_end
            |=> (first_err_reg == $past(first_err_reg)))
        else $error("first error overwritten within a set");

    // The packet counter stays saturated until the set ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (packets_reg == pscr_pkg::INDEX_MAX) && !set_end
            |=> (packets_reg == pscr_pkg::INDEX_MAX))
        else $error("packet counter left saturation");

endmodule

`default_nettype wire

[rtl/packet_set_reassembly_checker.sv]
// Packet set checker, CRC-16/CCITT-FALSE per packet: top level.
// Path: a packet-ending item passes the front stage register, the queue and the result register
// before its result shows, and takes longer while the queue holds items.
// Throughput: one item per cycle unless back-pressure stalls; the CRC byte step is combinational.
// Reset: asynchronous, active low; clears control and set state, register to 4560.
// Depends on pscr_pkg, pscr_front, pscr_queue and pscr_back.
`timescale 1ns / 1ps
`default_nettype none

module packet_set_reassembly_checker #(
    parameter int BYTE_COUNT_WIDTH = pscr_pkg::BYTE_COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH      = pscr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // expected_set_bytes write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pscr_pkg::CFG_WIDTH-1:0]      cfg_data,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // data_byte[7:0], header_seq[23:8], header_total[39:24], header_crc[55:40]
    input  wire logic [pscr_pkg::S_TDATA_WIDTH-1:0]  s_axis_tdata,
    // last_in_packet
    input  wire logic                                s_axis_tlast,
    // has_byte[0], last_packet[1]
    input  wire logic [pscr_pkg::S_TUSER_WIDTH-1:0]  s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // packet_index[15:0]
    output logic [pscr_pkg::M_TDATA_WIDTH-1:0]       m_axis_tdata,
    // set_done
    output logic                                     m_axis_tlast,
    // packet_good[0], set_status[3:1]
    output logic [pscr_pkg::M_TUSER_WIDTH-1:0]       m_axis_tuser
);

    logic [pscr_pkg::CFG_WIDTH-1:0] expected_set_bytes_reg;
    logic [pscr_pkg::CFG_WIDTH-1:0] expected_set_bytes_next;
    logic                           push_valid;
    logic                           push_ready;
    pscr_pkg::item_t                push_item;
    logic                           pop_valid;
    logic                           pop_ready;
    pscr_pkg::item_t                pop_item;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_comb
    begin
        expected_set_bytes_next = (cfg_valid && cfg_ready) ? cfg_data
                                                           : expected_set_bytes_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            expected_set_bytes_reg <= pscr_pkg::CFG_RESET;
        else
            expected_set_bytes_reg <= expected_set_bytes_next;
    end

    pscr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    pscr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    pscr_back #(
        .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .expected_set_bytes (expected_set_bytes_reg),
        .pop_valid          (pop_valid),
        .pop_ready          (pop_ready),
        .pop_item           (pop_item),
        .m_axis_tvalid      (m_axis_tvalid),
        .m_axis_tready      (m_axis_tready),
        .m_axis_tdata       (m_axis_tdata),
        .m_axis_tlast       (m_axis_tlast),
        .m_axis_tuser       (m_axis_tuser)
    );

endmodule

`default_nettype wire

[dv/tb_packet_set_reassembly_checker.sv]
// Self-checking testbench for packet_set_reassembly_checker: directed table and
// random packet sets, checked against the typed table verdicts or an in-bench model.
// Depends on pscr_pkg and the rtl top level only.
`timescale 1ns / 1ps

module tb_packet_set_reassembly_checker;

    localparam int RANDOM_ITEMS = 1250;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [15:0]       index;
        logic              good;
        logic              done;
        pscr_pkg::status_t status;
    } verdict_t;

    typedef struct {
        pscr_pkg::item_t it;
        bit              typed;
        verdict_t        want;
    } row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pscr_pkg::CFG_WIDTH-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [pscr_pkg::S_TDATA_WIDTH-1:0] s_axis_tdata = '0;
    logic s_axis_tlast = 1'b0;
    logic [pscr_pkg::S_TUSER_WIDTH-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [pscr_pkg::M_TDATA_WIDTH-1:0] m_axis_tdata;
    logic m_axis_tlast;
    logic [pscr_pkg::M_TUSER_WIDTH-1:0] m_axis_tuser;

    // Model of the set checker: per packet CRC, set counters, first error, register
    logic [15:0]                    pkt_crc = pscr_pkg::CRC_INIT;
    logic [15:0]                    pkt_count = '0;
    logic [23:0]                    set_bytes = '0;
    logic [15:0]                    set_total = '0;
    pscr_pkg::err_t                 set_err = pscr_pkg::ERR_NONE;
    logic [pscr_pkg::CFG_WIDTH-1:0] bytes_cfg = pscr_pkg::CFG_RESET;

    verdict_t pending_verdicts[$];
    row_t     dir_rows[$];

    bit idling_on = 1'b1;
    bit hold_off_req = 1'b0;
    int mismatches = 0;
    int items_taken = 0;
    int random_items = 0;
    int verdicts_checked = 0;
    int cfg_writes = 0;
    int status_seen[5] = '{default: 0};

    packet_set_reassembly_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // CRC-16/CCITT-FALSE, one input bit at a time against the top bit
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic fb;
        for (int i = 7; i >= 0; i--)
        begin
            fb = crc[15] ^ b[i];
            crc = {crc[14:0], 1'b0} ^ (fb ? pscr_pkg::CRC_POLY : 16'h0000);
        end
        return crc;
    endfunction

    // Advance the model by one item; report the packet verdict when a packet ends
    task automatic fold_item(input pscr_pkg::item_t it, output bit got, output verdict_t v);
        logic [15:0] idx;
        logic        seq_ok;
        logic        crc_ok;
        got = 1'b0;
        v = '0;
        if (it.has_byte)
        begin
            pkt_crc = crc16_step(pkt_crc, it.data_byte);
            if (set_bytes != 24'hFFFFFF)
                set_bytes++;
        end
        if (!it.last_in_packet)
            return;
        idx = pkt_count;
        seq_ok = it.header_seq == idx;
        crc_ok = it.header_crc == pkt_crc;
        if (set_err == pscr_pkg::ERR_NONE)
        begin
            if (!seq_ok)
                set_err = pscr_pkg::ERR_SEQ;
            else if (!crc_ok)
                set_err = pscr_pkg::ERR_CRC;
        end
        if (pkt_count == 16'h0000)
            set_total = it.header_total;
        if (pkt_count != pscr_pkg::INDEX_MAX)
            pkt_count++;
        pkt_crc = pscr_pkg::CRC_INIT;
        v.index = idx;
        v.good = seq_ok && crc_ok;
        v.done = it.last_packet;
        v.status = pscr_pkg::ST_OK;
        if (it.last_packet)
        begin
            if (pkt_count != set_total)
                v.status = pscr_pkg::ST_COUNT;
            else if (set_err == pscr_pkg::ERR_SEQ)
                v.status = pscr_pkg::ST_SEQ;
            else if (set_err == pscr_pkg::ERR_CRC)
                v.status = pscr_pkg::ST_CRC;
            else if (set_bytes != bytes_cfg)
                v.status = pscr_pkg::ST_BYTES;
            pkt_crc = pscr_pkg::CRC_INIT;
            pkt_count = '0;
            set_bytes = '0;
            set_total = '0;
            set_err = pscr_pkg::ERR_NONE;
        end
        got = 1'b1;
    endtask

    function automatic pscr_pkg::item_t scramble();
        pscr_pkg::item_t it;
        it.data_byte = 8'($urandom);
        it.has_byte = 1'($urandom);
        it.last_in_packet = 1'($urandom);
        it.last_packet = 1'($urandom);
        it.header_seq = 16'($urandom);
        it.header_total = 16'($urandom);
        it.header_crc = 16'($urandom);
        return it;
    endfunction

    function automatic void add_row(input logic [7:0] data, input bit hb, input bit lip,
                                    input bit lp, input logic [15:0] seq,
                                    input logic [15:0] tot, input logic [15:0] crc,
                                    input bit typed, input logic [15:0] idx, input bit good,
                                    input bit done, input pscr_pkg::status_t st);
        row_t r;
        r.it.data_byte = data;
        r.it.has_byte = hb;
        r.it.last_in_packet = lip;
        r.it.last_packet = lp;
        r.it.header_seq = seq;
        r.it.header_total = tot;
        r.it.header_crc = crc;
        r.typed = typed;
        r.want.index = idx;
        r.want.good = good;
        r.want.done = done;
        r.want.status = st;
        dir_rows.push_back(r);
    endfunction

    // Offer one item with random idle cycles ahead of it; fold it in once taken
    task automatic offer_item(input pscr_pkg::item_t it, input bit typed,
                              input verdict_t typed_v);
        bit       got;
        verdict_t v;
        while (idling_on && $urandom_range(99) < 16)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {it.header_crc, it.header_total, it.header_seq, it.data_byte};
        s_axis_tlast <= it.last_in_packet;
        s_axis_tuser <= {it.last_packet, it.has_byte};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        fold_item(it, got, v);
        if (got)
            pending_verdicts.push_back(typed ? typed_v : v);
        items_taken++;
    endtask

    task automatic offer_idle();
        pscr_pkg::item_t it;
        it = scramble();
        it.has_byte = 1'b0;
        it.last_in_packet = 1'b0;
        offer_item(it, 1'b0, '0);
    endtask

    // Stop sending, wait out every verdict plus the pipeline
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_set_bytes(input logic [pscr_pkg::CFG_WIDTH-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        bytes_cfg = value;
        cfg_writes++;
    endtask

    // One set of 1..5 packets carrying want_bytes in total, with occasional faults
    task automatic send_set(input int unsigned want_bytes);
        int unsigned     npkt;
        int unsigned     left;
        int unsigned     nb;
        logic [15:0]     crc;
        bit              ride;
        pscr_pkg::item_t it;
        npkt = $urandom_range(1, 5);
        left = want_bytes;
        for (int p = 0; p < npkt; p++)
        begin
            nb = (p == npkt - 1) ? left : $urandom_range(0, left);
            left -= nb;
            ride = (nb != 0) && ($urandom_range(1) == 1);
            crc = pscr_pkg::CRC_INIT;
            for (int b = 0; b < nb; b++)
            begin
                if ($urandom_range(99) < 5)
                    offer_idle();
                it = scramble();
                it.has_byte = 1'b1;
                it.last_in_packet = 1'b0;
                crc = crc16_step(crc, it.data_byte);
                // the last byte may ride on the packet-ending item
                if (!(ride && b == nb - 1))
                begin
                    offer_item(it, 1'b0, '0);
                    random_items++;
                end
            end
            if (!ride)
            begin
                it = scramble();
                it.has_byte = 1'b0;
            end
            it.last_in_packet = 1'b1;
            it.last_packet = (p == npkt - 1) ^ ($urandom_range(99) < 3);
            it.header_seq = ($urandom_range(99) < 8) ? 16'($urandom) : 16'(p);
            it.header_crc = ($urandom_range(99) < 8) ? 16'($urandom) : crc;
            if (p == 0 && $urandom_range(99) >= 10)
                it.header_total = 16'(npkt);
            offer_item(it, 1'b0, '0);
            random_items++;
        end
    endtask

    // Result side: random back-pressure, plus one long hold-off on request
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= !idling_on || ($urandom_range(99) >= 16);
        end
    end

    function automatic void flag_mismatch(input string what, input verdict_t want,
                                          input verdict_t seen);
        mismatches++;
        if (mismatches <= 10)
            $display({"MISMATCH %s: expected idx=%0d good=%0b done=%0b status=%0d,",
                      " got idx=%0d good=%0b done=%0b status=%0d"},
                     what, want.index, want.good, want.done, want.status,
                     seen.index, seen.good, seen.done, seen.status);
    endfunction

    // Compare each taken verdict with the oldest one predicted
    always @(posedge clk)
    begin : check_verdicts
        verdict_t seen;
        verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.index = m_axis_tdata;
            seen.good = m_axis_tuser[0];
            seen.done = m_axis_tlast;
            seen.status = pscr_pkg::status_t'(m_axis_tuser[3:1]);
            if (pending_verdicts.size() == 0)
                flag_mismatch("unexpected verdict", '0, seen);
            else
            begin
                want = pending_verdicts.pop_front();
                if (seen.index !== want.index || seen.good !== want.good ||
                    seen.done !== want.done || seen.status !== want.status)
                    flag_mismatch("verdict", want, seen);
                verdicts_checked++;
                if (want.done && want.status <= pscr_pkg::ST_BYTES)
                    status_seen[want.status]++;
            end
        end
    end

    initial
    begin : watchdog
        #50_000_000;
        $display("timeout with %0d verdicts outstanding", pending_verdicts.size());
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : main_flow
        logic [pscr_pkg::CFG_WIDTH-1:0] phase_cfg[8];
        int unsigned                    phase_start;
        int unsigned                    want_bytes;

        // Directed rows, register still at its reset value
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 16'h0000, 16'h0001, 16'hFFFF,
                1'b1, 16'd0, 1'b1, 1'b1, pscr_pkg::ST_BYTES);
        add_row(8'hFF, 1'b0, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                1'b0, 16'd0, 1'b0, 1'b0, pscr_pkg::ST_OK);
        add_row(8'h00, 1'b1, 1'b0, 1'b1, 16'h0000, 16'h0000, 16'h0000,
                1'b0, 16'd0, 1'b0, 1'b0, pscr_pkg::ST_OK);
        add_row(8'hFF, 1'b1, 1'b1, 1'b0, 16'h0000, 16'hFFFF, 16'h0000,
                1'b0, 16'd0, 1'b0, 1'b0, pscr_pkg::ST_OK);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, 16'hFFFF, 16'h0000, 16'hFFFF,
                1'b1, 16'd1, 1'b0, 1'b0, pscr_pkg::ST_OK);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 16'h0002, 16'h0000, 16'hFFFF,
                1'b1, 16'd2, 1'b1, 1'b1, pscr_pkg::ST_COUNT);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0002, 16'h0000,
                1'b1, 16'd0, 1'b0, 1'b0, pscr_pkg::ST_OK);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 16'h0001, 16'h0000, 16'hFFFF,
                1'b1, 16'd1, 1'b1, 1'b1, pscr_pkg::ST_CRC);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 16'h0005, 16'h0001, 16'h0000,
                1'b1, 16'd0, 1'b0, 1'b1, pscr_pkg::ST_SEQ);
        add_row(8'h00, 1'b0, 1'b1, 1'b0, 16'h0000, 16'h0002, 16'h1234,
                1'b1, 16'd0, 1'b0, 1'b0, pscr_pkg::ST_OK);
        add_row(8'h00, 1'b0, 1'b1, 1'b1, 16'h0007, 16'h0000, 16'hFFFF,
                1'b1, 16'd1, 1'b0, 1'b1, pscr_pkg::ST_CRC);
        // standard check string "123456789", CRC 0x29B1, last byte ends the set
        for (int i = 0; i < 9; i++)
            add_row(8'h31 + 8'(i), 1'b1, i == 8, i == 8, 16'h0000, 16'h0001,
                    (i == 8) ? 16'h29B1 : 16'h0000, i == 8, 16'd0, 1'b1, 1'b1,
                    pscr_pkg::ST_BYTES);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            offer_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

        // Random sets over several register settings, extremes included
        phase_cfg[0] = '0;
        phase_cfg[1] = 24'hFFFFFF;
        for (int k = 2; k < 6; k++)
            phase_cfg[k] = pscr_pkg::CFG_WIDTH'($urandom_range(1, 40));
        phase_cfg[6] = 24'd40;
        phase_cfg[7] = pscr_pkg::CFG_WIDTH'($urandom);
        for (int k = 0; k < 8; k++)
        begin
            write_set_bytes(phase_cfg[k]);
            // one phase runs both sides with no idling at all
            idling_on = (k != 6);
            if (k == 1)
                hold_off_req = 1'b1;
            phase_start = random_items;
            while (random_items - phase_start < RANDOM_ITEMS / 8)
            begin
                if (phase_cfg[k] <= 40 && $urandom_range(99) < 70)
                    want_bytes = phase_cfg[k];
                else
                    want_bytes = $urandom_range(0, 40);
                send_set(want_bytes);
            end
        end
        idling_on = 1'b1;

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d items (%0d in random sets), %0d verdicts, %0d register writes",
                 items_taken, random_items, verdicts_checked, cfg_writes);
        $display("sets closed by status ok/count/seq/crc/bytes: %0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0 && pending_verdicts.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[sim.f]
rtl/pscr_pkg.sv
rtl/pscr_front.sv
rtl/pscr_queue.sv
rtl/pscr_back.sv
rtl/packet_set_reassembly_checker.sv
dv/tb_packet_set_reassembly_checker.sv
